FILE: hdl/lssu_pkg.sv
// Package for the load, store and stack unit: item types, result kinds, opcodes.
// Used by every module of the unit; depends on nothing.
`timescale 1ns / 1ps

package lssu_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  opcode;
    logic [15:0] imm;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [4:0]  cycles;
    logic        not_in_group;
    logic        last;
    logic [15:0] reg_af;
    logic [15:0] reg_bc;
    logic [15:0] reg_de;
    logic [15:0] reg_hl;
    logic [15:0] reg_sp;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      count;
    out_item_t [2:0] item;
  } res_batch_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [3:0]  pend_tgt;
    logic [1:0]  pend_reads;
    logic [4:0]  pend_cyc;
  } arch_t;

  // physical register indexes
  localparam logic [2:0] IX_A = 3'd0;
  localparam logic [2:0] IX_F = 3'd1;
  localparam logic [2:0] IX_B = 3'd2;
  localparam logic [2:0] IX_C = 3'd3;
  localparam logic [2:0] IX_D = 3'd4;
  localparam logic [2:0] IX_E = 3'd5;
  localparam logic [2:0] IX_H = 3'd6;
  localparam logic [2:0] IX_L = 3'd7;

  localparam logic [2:0] REG_CODE_MEM = 3'd6;
  localparam logic [1:0] PAIR_SP      = 2'd3;

  localparam logic [7:0] HIGH_PAGE     = 8'hFF;
  localparam logic [7:0] LOW_NIB_MASK  = 8'hF0;

  localparam logic [7:0] OP_HALT       = 8'h76;
  localparam logic [7:0] OP_LD_BC_A    = 8'h02;
  localparam logic [7:0] OP_LD_DE_A    = 8'h12;
  localparam logic [7:0] OP_LD_A_BC    = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE    = 8'h1A;
  localparam logic [7:0] OP_LDI_HL_A   = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A   = 8'h32;
  localparam logic [7:0] OP_LDI_A_HL   = 8'h2A;
  localparam logic [7:0] OP_LDD_A_HL   = 8'h3A;
  localparam logic [7:0] OP_LD_NN_SP   = 8'h08;
  localparam logic [7:0] OP_LD_NN_A    = 8'hEA;
  localparam logic [7:0] OP_LD_A_NN    = 8'hFA;
  localparam logic [7:0] OP_LDH_N_A    = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N    = 8'hF0;
  localparam logic [7:0] OP_LDH_C_A    = 8'hE2;
  localparam logic [7:0] OP_LDH_A_C    = 8'hF2;
  localparam logic [7:0] OP_LD_SP_HL   = 8'hF9;
  localparam logic [7:0] OP_LD_HL_SPE  = 8'hF8;

  localparam logic [7:0] PAT_LD_R_R    = 8'b01??????;
  localparam logic [7:0] PAT_LD_R_N    = 8'b00???110;
  localparam logic [7:0] PAT_LD_RR_NN  = 8'b00??0001;
  localparam logic [7:0] PAT_PUSH      = 8'b11??0101;
  localparam logic [7:0] PAT_POP       = 8'b11??0001;

endpackage

FILE: hdl/lssu_exec.sv
// Execute logic: decodes one item against the register state and forms up to
// three results and the next state. Depends on lssu_pkg.
`timescale 1ns / 1ps

module lssu_exec import lssu_pkg::*; (
  input  in_item_t   item_i,
  input  arch_t      arch_i,
  output arch_t      arch_o,
  output res_batch_t batch_o
);

  function automatic logic [7:0] get_phys(arch_t s, logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      IX_A:    v = s.a;
      IX_F:    v = s.f;
      IX_B:    v = s.b;
      IX_C:    v = s.c;
      IX_D:    v = s.d;
      IX_E:    v = s.e;
      IX_H:    v = s.h;
      IX_L:    v = s.l;
      default: v = s.a;
    endcase
    return v;
  endfunction

  function automatic arch_t set_phys(arch_t s, logic [2:0] idx, logic [7:0] v);
    arch_t r;
    r = s;
    case (idx)
      IX_A:    r.a = v;
      IX_F:    r.f = v;
      IX_B:    r.b = v;
      IX_C:    r.c = v;
      IX_D:    r.d = v;
      IX_E:    r.e = v;
      IX_H:    r.h = v;
      IX_L:    r.l = v;
      default: r.a = v;
    endcase
    return r;
  endfunction

  // operand code of ld r,r' to physical index
  function automatic logic [2:0] reg_code_idx(logic [2:0] code);
    logic [2:0] ix;
    case (code)
      3'd0:    ix = IX_B;
      3'd1:    ix = IX_C;
      3'd2:    ix = IX_D;
      3'd3:    ix = IX_E;
      3'd4:    ix = IX_H;
      3'd5:    ix = IX_L;
      default: ix = IX_A;
    endcase
    return ix;
  endfunction

  function automatic logic [2:0] pair_base(logic [1:0] p);
    logic [2:0] ix;
    case (p)
      2'd0:    ix = IX_B;
      2'd1:    ix = IX_D;
      2'd2:    ix = IX_H;
      default: ix = IX_A;
    endcase
    return ix;
  endfunction

  function automatic logic [15:0] get_pair(arch_t s, logic [2:0] base);
    return {get_phys(s, base), get_phys(s, base + 3'd1)};
  endfunction

  function automatic arch_t set_pair(arch_t s, logic [2:0] base, logic [15:0] v);
    arch_t r;
    r = set_phys(s, base, v[15:8]);
    r = set_phys(r, base + 3'd1, v[7:0]);
    return r;
  endfunction

  function automatic out_item_t mk(kind_e k, logic [15:0] addr, logic [7:0] wd,
                                   logic [4:0] cyc, logic nig);
    out_item_t r;
    r              = '0;
    r.kind         = k;
    r.address      = addr;
    r.write_data   = wd;
    r.cycles       = cyc;
    r.not_in_group = nig;
    return r;
  endfunction

  always_comb begin
    arch_t           s;
    out_item_t [2:0] r;
    logic [1:0]      n;
    logic [7:0]      op;
    logic [7:0]      n8;
    logic [7:0]      rd;
    logic [15:0]     hl;
    logic [15:0]     pv;
    logic [15:0]     ext;
    logic [15:0]     sum;
    logic [8:0]      lo_sum;
    logic [4:0]      nib_sum;
    logic [2:0]      dst;
    logic [2:0]      src;
    logic [2:0]      base;
    logic [1:0]      p;

    s       = arch_i;
    r       = '0;
    n       = 2'd0;
    op      = item_i.opcode;
    n8      = item_i.imm[7:0];
    rd      = item_i.read_data;
    hl      = {arch_i.h, arch_i.l};
    dst     = op[5:3];
    src     = op[2:0];
    p       = op[5:4];
    base    = arch_i.pend_tgt[2:0];
    pv      = get_pair(arch_i, pair_base(p));
    ext     = {{8{n8[7]}}, n8};
    sum     = arch_i.sp + ext;
    lo_sum  = {1'b0, arch_i.sp[7:0]} + {1'b0, n8};
    nib_sum = {1'b0, arch_i.sp[3:0]} + {1'b0, n8[3:0]};

    if (item_i.req_type) begin
      if (arch_i.pend_reads != 2'd0) begin
        if (!arch_i.pend_tgt[3]) begin
          s = set_phys(s, base, rd);
          s.pend_reads = 2'd0;
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, arch_i.pend_cyc, 1'b0);
          n = 2'd1;
        end else if (arch_i.pend_reads == 2'd2) begin
          // first pop byte goes to the low register; flags keep no low nibble
          s = set_phys(s, base + 3'd1, (base == IX_A) ? (rd & LOW_NIB_MASK) : rd);
          s.pend_reads = 2'd1;
        end else begin
          s = set_phys(s, base, rd);
          s.pend_reads = 2'd0;
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, arch_i.pend_cyc, 1'b0);
          n = 2'd1;
        end
      end
    end else begin
      s.pend_reads = 2'd0;
      case (op) inside
        OP_HALT: begin
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd0, 1'b1);
          n = 2'd1;
        end
        PAT_LD_R_R: begin
          if (src == REG_CODE_MEM) begin
            r[0] = mk(KIND_READ, hl, 8'h00, 5'd0, 1'b0);
            s.pend_tgt   = {1'b0, reg_code_idx(dst)};
            s.pend_reads = 2'd1;
            s.pend_cyc   = 5'd8;
            n = 2'd1;
          end else if (dst == REG_CODE_MEM) begin
            r[0] = mk(KIND_WRITE, hl, get_phys(arch_i, reg_code_idx(src)), 5'd0, 1'b0);
            r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
            n = 2'd2;
          end else begin
            s = set_phys(s, reg_code_idx(dst), get_phys(arch_i, reg_code_idx(src)));
            r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd4, 1'b0);
            n = 2'd1;
          end
        end
        PAT_LD_R_N: begin
          if (dst == REG_CODE_MEM) begin
            r[0] = mk(KIND_WRITE, hl, n8, 5'd0, 1'b0);
            r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd12, 1'b0);
            n = 2'd2;
          end else begin
            s = set_phys(s, reg_code_idx(dst), n8);
            r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
            n = 2'd1;
          end
        end
        PAT_LD_RR_NN: begin
          if (p == PAIR_SP) begin
            s.sp = item_i.imm;
          end else begin
            s = set_pair(s, pair_base(p), item_i.imm);
          end
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd12, 1'b0);
          n = 2'd1;
        end
        PAT_PUSH: begin
          s.sp = arch_i.sp - 16'd2;
          r[0] = mk(KIND_WRITE, arch_i.sp - 16'd1, pv[15:8], 5'd0, 1'b0);
          r[1] = mk(KIND_WRITE, arch_i.sp - 16'd2, pv[7:0], 5'd0, 1'b0);
          r[2] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd16, 1'b0);
          n = 2'd3;
        end
        PAT_POP: begin
          r[0] = mk(KIND_READ, arch_i.sp, 8'h00, 5'd0, 1'b0);
          r[1] = mk(KIND_READ, arch_i.sp + 16'd1, 8'h00, 5'd0, 1'b0);
          s.sp         = arch_i.sp + 16'd2;
          s.pend_tgt   = {1'b1, pair_base(p)};
          s.pend_reads = 2'd2;
          s.pend_cyc   = 5'd12;
          n = 2'd2;
        end
        OP_LD_BC_A, OP_LD_DE_A: begin
          r[0] = mk(KIND_WRITE, get_pair(arch_i, (op == OP_LD_BC_A) ? IX_B : IX_D),
                    arch_i.a, 5'd0, 1'b0);
          r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
          n = 2'd2;
        end
        OP_LD_A_BC, OP_LD_A_DE: begin
          r[0] = mk(KIND_READ, get_pair(arch_i, (op == OP_LD_A_BC) ? IX_B : IX_D),
                    8'h00, 5'd0, 1'b0);
          s.pend_tgt   = {1'b0, IX_A};
          s.pend_reads = 2'd1;
          s.pend_cyc   = 5'd8;
          n = 2'd1;
        end
        OP_LDI_HL_A, OP_LDD_HL_A: begin
          r[0] = mk(KIND_WRITE, hl, arch_i.a, 5'd0, 1'b0);
          s = set_pair(s, IX_H, (op == OP_LDI_HL_A) ? hl + 16'd1 : hl - 16'd1);
          r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
          n = 2'd2;
        end
        OP_LDI_A_HL, OP_LDD_A_HL: begin
          r[0] = mk(KIND_READ, hl, 8'h00, 5'd0, 1'b0);
          s = set_pair(s, IX_H, (op == OP_LDI_A_HL) ? hl + 16'd1 : hl - 16'd1);
          s.pend_tgt   = {1'b0, IX_A};
          s.pend_reads = 2'd1;
          s.pend_cyc   = 5'd8;
          n = 2'd1;
        end
        OP_LD_NN_SP: begin
          r[0] = mk(KIND_WRITE, item_i.imm, arch_i.sp[7:0], 5'd0, 1'b0);
          r[1] = mk(KIND_WRITE, item_i.imm + 16'd1, arch_i.sp[15:8], 5'd0, 1'b0);
          r[2] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd20, 1'b0);
          n = 2'd3;
        end
        OP_LD_NN_A: begin
          r[0] = mk(KIND_WRITE, item_i.imm, arch_i.a, 5'd0, 1'b0);
          r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd16, 1'b0);
          n = 2'd2;
        end
        OP_LD_A_NN: begin
          r[0] = mk(KIND_READ, item_i.imm, 8'h00, 5'd0, 1'b0);
          s.pend_tgt   = {1'b0, IX_A};
          s.pend_reads = 2'd1;
          s.pend_cyc   = 5'd16;
          n = 2'd1;
        end
        OP_LDH_N_A: begin
          r[0] = mk(KIND_WRITE, {HIGH_PAGE, n8}, arch_i.a, 5'd0, 1'b0);
          r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd12, 1'b0);
          n = 2'd2;
        end
        OP_LDH_A_N: begin
          r[0] = mk(KIND_READ, {HIGH_PAGE, n8}, 8'h00, 5'd0, 1'b0);
          s.pend_tgt   = {1'b0, IX_A};
          s.pend_reads = 2'd1;
          s.pend_cyc   = 5'd12;
          n = 2'd1;
        end
        OP_LDH_C_A: begin
          r[0] = mk(KIND_WRITE, {HIGH_PAGE, arch_i.c}, arch_i.a, 5'd0, 1'b0);
          r[1] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
          n = 2'd2;
        end
        OP_LDH_A_C: begin
          r[0] = mk(KIND_READ, {HIGH_PAGE, arch_i.c}, 8'h00, 5'd0, 1'b0);
          s.pend_tgt   = {1'b0, IX_A};
          s.pend_reads = 2'd1;
          s.pend_cyc   = 5'd8;
          n = 2'd1;
        end
        OP_LD_SP_HL: begin
          s.sp = hl;
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd8, 1'b0);
          n = 2'd1;
        end
        OP_LD_HL_SPE: begin
          // z and n cleared, h and c from the low byte add
          s.f = {2'b00, nib_sum[4], lo_sum[8], 4'h0};
          s = set_pair(s, IX_H, sum);
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd12, 1'b0);
          n = 2'd1;
        end
        default: begin
          r[0] = mk(KIND_DONE, 16'h0000, 8'h00, 5'd0, 1'b1);
          n = 2'd1;
        end
      endcase
    end

    // snapshot after the whole update on every result of this item
    for (int k = 0; k < 3; k++) begin
      r[k].last   = (2'(k) == (n - 2'd1)) && (n != 2'd0);
      r[k].reg_af = {s.a, s.f};
      r[k].reg_bc = {s.b, s.c};
      r[k].reg_de = {s.d, s.e};
      r[k].reg_hl = {s.h, s.l};
      r[k].reg_sp = s.sp;
    end

    arch_o        = s;
    batch_o.count = n;
    batch_o.item  = r;
  end

endmodule

FILE: hdl/lssu_out_queue.sv
// Result queue: output register plus two held results, drained one item a cycle
// while the output is not stalled. Depends on lssu_pkg.
`timescale 1ns / 1ps

module lssu_out_queue import lssu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_batch_t batch_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic            out_valid_q;
  logic [1:0]      rest_cnt_q;
  out_item_t       out_q;
  out_item_t [1:0] rest_q;
  logic            out_fire;
  logic            advance;

  assign out_fire = out_valid_q && !out_stall_i;
  assign advance  = !out_valid_q || out_fire;
  assign free_o   = (rest_cnt_q == 2'd0) && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rest_cnt_q  <= 2'd0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
      rest_cnt_q  <= batch_i.count - 2'd1;
    end else if (advance) begin
      if (rest_cnt_q != 2'd0) begin
        out_valid_q <= 1'b1;
        rest_cnt_q  <= rest_cnt_q - 2'd1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q     <= batch_i.item[0];
      rest_q[0] <= batch_i.item[1];
      rest_q[1] <= batch_i.item[2];
    end else if (advance && (rest_cnt_q != 2'd0)) begin
      out_q     <= rest_q[0];
      rest_q[0] <= rest_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hdl/cpu_load_store_stack_unit_core.sv
// Load, store and stack unit of the 8-bit CPU: an accepted item is
// registered, then its results go to the single result register and
// leave the output port one after another, so one item a cycle when
// each gives one result and the output is not stalled.
// Reset clears all registers, SP and any pending read; no clearing pass.
`timescale 1ns / 1ps

module cpu_load_store_stack_unit_core import lssu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       in_valid_q;
  in_item_t   in_q;
  arch_t      arch_q;
  arch_t      arch_d;
  res_batch_t batch;
  logic       q_free;
  logic       exec_fire;
  logic       q_load;

  lssu_exec u_exec (
    .item_i  (in_q),
    .arch_i  (arch_q),
    .arch_o  (arch_d),
    .batch_o (batch)
  );

  assign exec_fire  = in_valid_q && ((batch.count == 2'd0) || q_free);
  assign q_load     = exec_fire && (batch.count != 2'd0);
  assign in_stall_o = in_valid_q && !exec_fire;

  lssu_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (q_load),
    .batch_i     (batch),
    .free_o      (q_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      arch_q     <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (exec_fire) begin
        in_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        arch_q <= arch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_load |-> q_free)
    else $error("results loaded while the queue still held items");

  a_batch_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_item_o.last) |=> out_valid_o)
    else $error("gap inside the results of one item");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_DONE)) |->
      ((out_item_o.address == 16'h0000) && (out_item_o.write_data == 8'h00)))
    else $error("done result carries an address or data");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_DONE)) |-> out_item_o.last)
    else $error("done result not marked last");
`endif

endmodule
